/* src/tip_pkg.sv */
// Shared types and constants of the text-to-integer parser.
`default_nettype none
package tip_pkg;

	localparam longint unsigned COUNT_LIMIT_DEF = 64'd65535;

	localparam int CHAR_W  = 8;
	localparam int RADIX_W = 6;
	localparam int VALUE_W = 64;
	localparam int USED_W  = 16;

	// base selection for the digit check of the current character
	localparam logic [1:0] BSEL_KEEP  = 2'd0;
	localparam logic [1:0] BSEL_TEN   = 2'd1;
	localparam logic [1:0] BSEL_EIGHT = 2'd2;
	localparam logic [1:0] BSEL_HEX   = 2'd3;

	// commands from the controller to the datapath, valid for one accepted request
	typedef struct packed {
		logic       step;      // a character is accepted this cycle
		logic       start;     // the character opens a new string
		logic [1:0] base_sel;  // base used for the digit check
		logic       base_wr;   // store the selected base
		logic       sign_wr;   // store the sign character
		logic       bump;      // advance the character count
		logic       acc_wr;    // store the multiply-add result
		logic       sat_wr;    // clamp the accumulator to the limit
		logic       load_out;  // capture a result
		logic       out_sat;   // result was clamped
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic is_space;
		logic is_sign;
		logic is_zero;
		logic is_x;
		logic base_is_0;
		logic base_0or16;
		logic digit_ok;
		logic ovf;
	} stat_t;

endpackage
`default_nettype wire

/* src/tip_ctrl.sv */
// Parse phase controller and output handshake of the text-to-integer parser.
`default_nettype none
module tip_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire logic           start,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	input  wire tip_pkg::stat_t st,
	output tip_pkg::cmd_t       cmd
);
	import tip_pkg::*;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_LEAD   = 3'd1;
	localparam logic [2:0] PH_PREFIX = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_DIGITS = 3'd4;

	logic [2:0] phase_q;
	logic [2:0] phase_nx;
	logic [2:0] phase_e;
	logic       out_valid_q;
	logic       go;
	logic       to_prefix;
	logic       to_digits;
	logic [1:0] sel;

	assign s_tready = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign go       = s_tvalid && s_tready;
	assign phase_e  = start ? PH_LEAD : phase_q;

	always_comb begin
		cmd       = '0;
		phase_nx  = phase_q;
		to_prefix = 1'b0;
		to_digits = 1'b0;
		sel       = BSEL_KEEP;
		if (go) begin
			cmd.step  = 1'b1;
			cmd.start = start;
			phase_nx  = phase_e;
			unique case (phase_e)
				PH_LEAD: begin
					if (st.is_space) begin
						cmd.bump = 1'b1;
					end else if (st.is_sign) begin
						cmd.sign_wr = 1'b1;
						cmd.bump    = 1'b1;
						phase_nx    = PH_PREFIX;
					end else begin
						to_prefix = 1'b1;
					end
				end
				PH_PREFIX: to_prefix = 1'b1;
				PH_ZERO: begin
					if (st.is_x) begin
						cmd.bump    = 1'b1;
						cmd.base_wr = 1'b1;
						sel         = BSEL_HEX;
						phase_nx    = PH_DIGITS;
					end else begin
						to_digits = 1'b1;
						sel       = st.base_is_0 ? BSEL_EIGHT : BSEL_KEEP;
					end
				end
				PH_DIGITS: to_digits = 1'b1;
				default: phase_nx = PH_IDLE;
			endcase
			if (to_prefix) begin
				if (st.base_0or16 && st.is_zero) begin
					cmd.bump = 1'b1;
					phase_nx = PH_ZERO;
				end else begin
					to_digits = 1'b1;
					sel       = st.base_is_0 ? BSEL_TEN : BSEL_KEEP;
				end
			end
			if (to_digits) begin
				cmd.base_wr = 1'b1;
				if (!st.digit_ok) begin
					cmd.load_out = 1'b1;
					phase_nx     = PH_IDLE;
				end else if (st.ovf) begin
					cmd.sat_wr   = 1'b1;
					cmd.load_out = 1'b1;
					cmd.out_sat  = 1'b1;
					phase_nx     = PH_IDLE;
				end else begin
					cmd.acc_wr = 1'b1;
					cmd.bump   = 1'b1;
					phase_nx   = PH_DIGITS;
				end
			end
			cmd.base_sel = sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_load_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("result captured over an untaken result");
	a_idle_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (phase_q == PH_IDLE))
		else $error("parse continues after its result");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> out_valid_q)
		else $error("pending result dropped");
	a_no_digit_work_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_wr || cmd.sat_wr) |-> (go && (phase_e == PH_PREFIX || phase_e == PH_ZERO
		|| phase_e == PH_DIGITS || phase_e == PH_LEAD)))
		else $error("accumulator written outside a parse");

endmodule
`default_nettype wire

/* src/tip_dp.sv */
// Datapath of the text-to-integer parser: character decode, accumulator, count, result.
`default_nettype none
module tip_dp #(
	parameter longint unsigned COUNT_LIMIT = tip_pkg::COUNT_LIMIT_DEF,
	parameter int              CNT_W       = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	input  wire logic [tip_pkg::RADIX_W-1:0]   cfg_data,
	input  wire logic [tip_pkg::CHAR_W-1:0]    char_code,
	input  wire tip_pkg::cmd_t                 cmd,
	output tip_pkg::stat_t                     st,
	output logic [tip_pkg::VALUE_W-1:0]        value,
	output logic [tip_pkg::USED_W-1:0]         chars_used,
	output logic                               saturated
);
	import tip_pkg::*;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_Z     = 8'h7A;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CASE_BIT = 8'h20;

	localparam logic [1:0] LK_UNS = 2'd0;
	localparam logic [1:0] LK_POS = 2'd1;
	localparam logic [1:0] LK_NEG = 2'd2;

	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_LIMIT);

	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] base_q;
	logic               neg_q;
	logic [1:0]         lk_q;
	logic [VALUE_W-1:0] acc_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [RADIX_W-1:0] base_e;
	logic [RADIX_W-1:0] base_d;
	logic               neg_e;
	logic [1:0]         lk_e;
	logic [VALUE_W-1:0] acc_e;
	logic [CNT_W-1:0]   cnt_e;

	logic [7:0]         lc;
	logic               is_num;
	logic               is_alpha;
	logic [5:0]         dig;
	logic [VALUE_W-1:0] lim;
	logic [69:0]        prod;
	logic [70:0]        sum;
	logic [VALUE_W-1:0] acc_fin;
	logic [CNT_W+15:0]  cnt_ext;

	// a new string sees cleared state and the configured radix
	assign base_e = cmd.start ? radix_q : base_q;
	assign neg_e  = cmd.start ? 1'b0 : neg_q;
	assign lk_e   = cmd.start ? LK_UNS : lk_q;
	assign acc_e  = cmd.start ? '0 : acc_q;
	assign cnt_e  = cmd.start ? '0 : cnt_q;

	always_comb begin
		case (cmd.base_sel)
			BSEL_TEN:   base_d = RADIX_W'(10);
			BSEL_EIGHT: base_d = RADIX_W'(8);
			BSEL_HEX:   base_d = RADIX_W'(16);
			default:    base_d = base_e;
		endcase
	end

	always_comb begin
		case (lk_e)
			LK_POS:  lim = {1'b0, {(VALUE_W-1){1'b1}}};
			LK_NEG:  lim = {1'b1, {(VALUE_W-1){1'b0}}};
			default: lim = '1;
		endcase
	end

	assign lc       = char_code | CASE_BIT;
	assign is_num   = (char_code >= CH_0) && (char_code <= CH_9);
	assign is_alpha = (lc >= CH_A) && (lc <= CH_Z);
	assign dig      = is_num ? 6'(char_code - CH_0) : 6'(lc - CH_A + 8'd10);

	assign prod = 70'(acc_e) * 70'(base_d);
	assign sum  = {1'b0, prod} + 71'(dig);

	assign st.is_space   = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
	assign st.is_sign    = (char_code == CH_MINUS) || (char_code == CH_PLUS);
	assign st.is_zero    = (char_code == CH_0);
	assign st.is_x       = (lc == CH_X);
	assign st.base_is_0  = (base_e == '0);
	assign st.base_0or16 = (base_e == '0) || (base_e == RADIX_W'(16));
	assign st.digit_ok   = (is_num || is_alpha) && (base_d >= RADIX_W'(2))
		&& (base_d <= RADIX_W'(36)) && (dig < base_d);
	assign st.ovf        = sum > {7'b0, lim};

	assign acc_fin = cmd.sat_wr ? lim : acc_e;
	assign cnt_ext = {16'b0, cnt_e};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= '0;
			base_q  <= '0;
			neg_q   <= 1'b0;
			lk_q    <= LK_UNS;
			acc_q   <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_valid) begin
				radix_q <= cfg_data;
			end
			if (cmd.step) begin
				base_q <= cmd.base_wr ? base_d : base_e;
				neg_q  <= cmd.sign_wr ? (char_code == CH_MINUS) : neg_e;
				if (cmd.sign_wr) begin
					lk_q <= (char_code == CH_MINUS) ? LK_NEG : LK_POS;
				end else begin
					lk_q <= lk_e;
				end
				if (cmd.sat_wr) begin
					acc_q <= lim;
				end else if (cmd.acc_wr) begin
					acc_q <= sum[VALUE_W-1:0];
				end else begin
					acc_q <= acc_e;
				end
				if (cmd.bump && (cnt_e < CNT_MAX)) begin
					cnt_q <= cnt_e + 1'b1;
				end else begin
					cnt_q <= cnt_e;
				end
			end
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			value      <= neg_e ? (VALUE_W'(0) - acc_fin) : acc_fin;
			chars_used <= (acc_fin != '0) ? cnt_ext[15:0] : '0;
			saturated  <= cmd.out_sat;
		end
	end

endmodule
`default_nettype wire

/* src/text_to_integer_parser.sv */
// Top level of the streaming text-to-integer parser.
// Streaming string-to-integer converter with strtoll behavior. Feed one character
// per request on the slave side; tuser marks the first character of a string. Leading
// whitespace is skipped, an optional sign is read, and with radix 0 the base comes from
// the prefix (0x/0X hex, leading 0 octal, else decimal); radix 16 also skips a 0x prefix.
// The first character that is not a digit of the base ends the number and produces one
// result request: the value (two's complement, negated after '-'), the count of
// characters used (0 when the magnitude is 0) and a flag set when the value was clamped
// to 2^64-1, 2^63-1 after '+' or 2^63 after '-'. The terminating character is consumed
// and not counted; characters outside a string are dropped. Throughput is one character
// per clock: the 64-by-6 multiply-add and the limit compare finish in the accept cycle.
// A result sits in an output register, and the slave side stalls only while that
// register is full and the master side is not taking it. Write the radix on the cfg
// channel only while no string is in flight; it applies from the next string start.
`default_nettype none
module text_to_integer_parser #(
	parameter longint unsigned COUNT_LIMIT = tip_pkg::COUNT_LIMIT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// slave side
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic [0:0]  s_tuser,   // [0] starts_string
	// master side
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [79:0]      m_tdata,   // [63:0] value, [79:64] chars_used
	output logic [0:0]       m_tuser,   // [0] saturated
	// radix register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [5:0]  cfg_data   // [5:0] radix
);
	import tip_pkg::*;

	localparam int CNT_W = $clog2(COUNT_LIMIT + 1);

	cmd_t               cmd;
	stat_t              st;
	logic [VALUE_W-1:0] value;
	logic [USED_W-1:0]  chars_used;
	logic               saturated;

	// the radix register takes a write in any cycle
	assign cfg_ready = 1'b1;

	tip_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.start    (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	tip_dp #(
		.COUNT_LIMIT (COUNT_LIMIT),
		.CNT_W       (CNT_W)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.char_code  (s_tdata),
		.cmd        (cmd),
		.st         (st),
		.value      (value),
		.chars_used (chars_used),
		.saturated  (saturated)
	);

	assign m_tdata = {chars_used, value};
	assign m_tuser = saturated;

endmodule
`default_nettype wire

/* tb/parse_result_checker.sv */
`timescale 1ns / 1ps
// Result checker for the text-to-integer parser: tracks the parse, predicts results, compares.
module parse_result_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic [0:0]  s_tuser,   // [0] starts_string
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [79:0] m_tdata,   // [63:0] value, [79:64] chars_used
	input  wire logic [0:0]  m_tuser,   // [0] saturated
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [5:0]  cfg_data,  // [5:0] radix
	output int               mismatches,
	output int               outstanding
);

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_PLUS    = "+";
	localparam logic [7:0] CH_MINUS   = "-";
	localparam logic [7:0] CH_ZERO    = "0";
	localparam logic [7:0] CH_NINE    = "9";
	localparam logic [7:0] CH_LOWER_A = "a";
	localparam logic [7:0] CH_LOWER_Z = "z";
	localparam logic [7:0] CH_LOWER_X = "x";
	localparam logic [7:0] CASE_BIT   = 8'h20;
	localparam int unsigned NOT_A_DIGIT = 99;

	localparam logic [63:0] MAX_UNSIGNED = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MAX_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN_MAGNITUDE = 64'h8000_0000_0000_0000;

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_LEAD,
		SCAN_PREFIX,
		SCAN_ZERO,
		SCAN_DIGITS
	} scan_e;

	typedef enum logic [1:0] {
		CLAMP_UNSIGNED,
		CLAMP_POSITIVE,
		CLAMP_NEGATIVE
	} clamp_e;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] used;
		logic        sat;
	} number_t;

	number_t     pending_numbers[$];
	logic [5:0]  radix_reg;
	scan_e       scan;
	logic        negate;
	clamp_e      clamp;
	logic [5:0]  base;
	logic [63:0] magnitude;
	int unsigned char_total;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic int unsigned char_digit(input logic [7:0] c);
		logic [7:0] lower;
		lower = c | CASE_BIT;
		if (c >= CH_ZERO && c <= CH_NINE)
			return c - CH_ZERO;
		if (lower >= CH_LOWER_A && lower <= CH_LOWER_Z)
			return lower - CH_LOWER_A + 10;
		return NOT_A_DIGIT;
	endfunction

	task automatic count_char();
		if (char_total < tip_pkg::COUNT_LIMIT_DEF)
			char_total++;
	endtask

	task automatic close_number(input logic sat);
		number_t n;
		n.value = negate ? 64'd0 - magnitude : magnitude;
		n.used  = (magnitude != 0) ? char_total[15:0] : 16'd0;
		n.sat   = sat;
		pending_numbers.push_back(n);
		scan = SCAN_IDLE;
	endtask

	task automatic consume_char(input logic [7:0] c, input logic first);
		int unsigned d;
		logic [63:0] ceiling;
		logic [71:0] wide;
		if (first) begin
			scan      = SCAN_LEAD;
			negate    = 1'b0;
			clamp     = CLAMP_UNSIGNED;
			base      = radix_reg;
			magnitude = '0;
			char_total = 0;
		end
		if (scan == SCAN_LEAD) begin
			if (is_blank(c)) begin
				count_char();
				return;
			end
			if (c == CH_MINUS || c == CH_PLUS) begin
				negate = (c == CH_MINUS);
				clamp  = negate ? CLAMP_NEGATIVE : CLAMP_POSITIVE;
				count_char();
				scan = SCAN_PREFIX;
				return;
			end
			scan = SCAN_PREFIX;
		end
		if (scan == SCAN_PREFIX) begin
			// a leading zero may open a hex or octal prefix
			if ((base == 0 || base == 16) && c == CH_ZERO) begin
				count_char();
				scan = SCAN_ZERO;
				return;
			end
			if (base == 0)
				base = 6'd10;
			scan = SCAN_DIGITS;
		end else if (scan == SCAN_ZERO) begin
			if ((c | CASE_BIT) == CH_LOWER_X) begin
				count_char();
				base = 6'd16;
				scan = SCAN_DIGITS;
				return;
			end
			if (base == 0)
				base = 6'd8;
			scan = SCAN_DIGITS;
		end
		if (scan != SCAN_DIGITS)
			return;
		d = char_digit(c);
		if (base < 2 || base > 36 || d >= base) begin
			close_number(1'b0);
			return;
		end
		case (clamp)
			CLAMP_POSITIVE: ceiling = MAX_POSITIVE;
			CLAMP_NEGATIVE: ceiling = MIN_MAGNITUDE;
			default:        ceiling = MAX_UNSIGNED;
		endcase
		// exact overflow check in a wider word
		wide = magnitude * 72'(base) + 72'(d);
		if (wide > 72'(ceiling)) begin
			magnitude = ceiling;
			close_number(1'b1);
			return;
		end
		magnitude = wide[63:0];
		count_char();
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch on %s: got %h, want %h", $realtime, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		number_t want;
		if (!arst_n) begin
			pending_numbers.delete();
			radix_reg   = '0;
			scan        = SCAN_IDLE;
			negate      = 1'b0;
			clamp       = CLAMP_UNSIGNED;
			base        = '0;
			magnitude   = '0;
			char_total  = 0;
			outstanding = 0;
			mismatches  = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				radix_reg = cfg_data;
			if (s_tvalid && s_tready)
				consume_char(s_tdata, s_tuser[0]);
			if (m_tvalid && m_tready) begin
				if (pending_numbers.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[63:0], '0);
				end else begin
					want = pending_numbers.pop_front();
					if (m_tdata[63:0] !== want.value)
						report_mismatch("value", m_tdata[63:0], want.value);
					if (m_tdata[79:64] !== want.used)
						report_mismatch("chars_used", 64'(m_tdata[79:64]), 64'(want.used));
					if (m_tuser[0] !== want.sat)
						report_mismatch("saturated", 64'(m_tuser[0]), 64'(want.sat));
				end
			end
			outstanding = pending_numbers.size();
		end
	end

endmodule

/* tb/tb_text_to_integer_parser.sv */
`timescale 1ns / 1ps
// Testbench top for the text-to-integer parser: clock, reset, stimulus, back-pressure and verdict.
module tb_text_to_integer_parser;

	// chance in percent that a side idles in a given cycle
	localparam int IDLE_PCT = 25;
	// cycles to let the block settle after the last expected result
	localparam int SETTLE_CYCLES = 4;
	// cycles with no request moved on any channel before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// lower bound on the characters sent per random phase
	localparam int PHASE_CHARS = 4;
	localparam logic [7:0] SPACE_CHAR = " ";
	// any phase of a string in flight ends on this character
	localparam logic [7:0] CLOSE_CHAR = "!";

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] char_code
	logic [0:0]  s_tuser;    // [0] starts_string
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;    // [63:0] value, [79:64] chars_used
	logic [0:0]  m_tuser;    // [0] saturated
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;   // [5:0] radix

	int          mismatches;
	int          outstanding;
	bit          bursty;
	int unsigned chars_sent;
	int          stall_cycles = 0;

	text_to_integer_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	parse_result_checker result_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Drain side: stall at random while bursty, otherwise always take the result.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= !(bursty && $urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Hang detection: count cycles in which no request moves on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Offer one character and hold it until accepted. Called at a falling edge and
	// returns at a falling edge with tvalid still high, so a following character
	// reuses the same assertion without a drop in between unless it idles first.
	task automatic push_char(input logic [7:0] c, input logic first);
		while (bursty && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tuser  <= first;
		do
			@(posedge clk);
		while (!s_tready);
		chars_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], i == 0);
	endtask

	// Drop the request, wait for every predicted result, then let the block settle
	// in case it is still working on a character that produces nothing.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Close any string in flight, wait for idle, then write the radix.
	task automatic set_radix(input logic [5:0] value);
		push_char(CLOSE_CHAR, 1'b0);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] digit_char(input int unsigned v);
		if (v < 10)
			return 8'("0" + v);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
	endfunction

	// Build one string: optional blanks, sign and prefix, digits of the base in use
	// (sometimes long enough to overflow), then an ender, a random byte or nothing.
	task automatic send_random_string(input logic [5:0] rdx);
		logic [7:0]  text[$];
		string       enders = " ;,.!/:@[{";
		int unsigned digit_base;
		int unsigned ndig;
		int unsigned pick;
		repeat ($urandom_range(0, 2)) begin
			pick = $urandom_range(0, 5);
			text.push_back(pick == 0 ? SPACE_CHAR : 8'(8 + pick));
		end
		pick = $urandom_range(0, 3);
		if (pick == 1)
			text.push_back("+");
		else if (pick == 2)
			text.push_back("-");
		digit_base = (rdx >= 2 && rdx <= 36) ? rdx : 10;
		pick = $urandom_range(0, 9);
		if ((rdx == 0 || rdx == 16) && pick < 4) begin
			text.push_back("0");
			text.push_back(pick[0] ? "x" : "X");
			digit_base = 16;
		end else if (rdx == 0 && pick < 6) begin
			text.push_back("0");
			digit_base = 8;
		end else if (pick == 9) begin
			// 0x prefix also where the base does not call for one
			text.push_back("0");
			text.push_back("x");
		end
		if ($urandom_range(0, 99) < 15) begin
			if (digit_base == 2)
				ndig = $urandom_range(60, 70);
			else if (digit_base <= 4)
				ndig = $urandom_range(32, 45);
			else
				ndig = $urandom_range(14, 30);
		end else begin
			ndig = $urandom_range(0, 10);
		end
		repeat (ndig) text.push_back(digit_char($urandom_range(0, digit_base - 1)));
		pick = $urandom_range(0, 3);
		if (pick < 2)
			text.push_back(enders[$urandom_range(0, enders.len() - 1)]);
		else if (pick == 2)
			text.push_back(8'($urandom_range(0, 255)));
		if (text.size() == 0)
			text.push_back(8'($urandom_range(0, 255)));
		foreach (text[i])
			push_char(text[i], i == 0);
		// stray bytes: dropped while idle, otherwise they continue the parse
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(0, 255)), 1'b0);
	endtask

	initial begin : stimulus
		int unsigned phase_start;
		bit          paused;
		int          radix_plan[$];
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		arst_n     = 1'b0;
		bursty     = 1'b1;
		chars_sent = 0;
		paused     = 1'b0;
		radix_plan = '{0, 10, 16, 8, 2, 36, 0, 1, 37, 63, 16};
		radix_plan.push_back($urandom_range(0, 63));
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, radix detected from the prefix (reset value).
		send_text("\011\012\013\014\015 42x");          // every blank kind
		push_char("7", 1'b0);                          // dropped: parser idle
		push_char("8", 1'b0);
		send_text(" -0x1F;");
		send_text("+077 ");
		send_text("0x;");                              // prefix with no digits
		send_text("089");                              // octal stops on 8
		send_text("18446744073709551615 ");            // unsigned maximum
		send_text("18446744073709551616 ");            // unsigned overflow
		send_text("+9223372036854775808 ");            // overflow after plus
		send_text("-9223372036854775808 ");            // exact negative limit
		send_text("-9223372036854775809 ");            // overflow after minus
		send_text("12");                               // abandoned by a restart
		send_text("34 ");
		send_text("-;");
		send_text("z");

		set_radix(6'd16);
		send_text("0XfF.");
		send_text("Ab ");
		set_radix(6'd36);
		send_text("zZ!");
		send_text("zzzzzzzzzzzzzz ");
		set_radix(6'd2);
		// long binary strings run without idling on either side
		bursty <= 1'b0;
		for (int i = 0; i < 64; i++)
			push_char("1", i == 0);
		push_char("2", 1'b0);
		for (int i = 0; i < 65; i++)
			push_char("1", i == 0);
		bursty <= 1'b1;
		set_radix(6'd1);                               // invalid: no digit accepted
		send_text("5 ");
		set_radix(6'd63);
		send_text("+1 ");

		// Random part: one phase per radix setting; one phase runs without idling.
		foreach (radix_plan[p]) begin
			set_radix(6'(radix_plan[p]));
			bursty <= (p != 3);
			phase_start = chars_sent;
			while (chars_sent - phase_start < PHASE_CHARS) begin
				if ($urandom_range(0, 99) < 8) begin
					repeat ($urandom_range(1, 4))
						push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end else begin
					send_random_string(6'(radix_plan[p]));
				end
				// hold the sender once until the drain side has caught up
				if (p == 1 && !paused && chars_sent - phase_start >= PHASE_CHARS / 2) begin
					settle();
					paused = 1'b1;
				end
			end
		end

		settle();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* text_to_integer_parser.f */
src/tip_pkg.sv
src/tip_ctrl.sv
src/tip_dp.sv
src/text_to_integer_parser.sv
tb/parse_result_checker.sv
tb/tb_text_to_integer_parser.sv
